// ===== rtl/nspc_pkg.sv =====
// Package for the nearest set point classifier.
// Holds function codes, register indexes, widths and shared types. No dependencies.
package nspc_pkg;

    // Function codes of an input request.
    typedef enum logic [1:0] {
        FUNC_START    = 2'd0,
        FUNC_SEED     = 2'd1,
        FUNC_CLASSIFY = 2'd2,
        FUNC_NONE     = 2'd3
    } func_t;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        REG_HEIGHT_SPLIT = 2'd0,
        REG_LIMIT_HIGH   = 2'd1,
        REG_LIMIT_LOW    = 2'd2,
        REG_UNUSED       = 2'd3
    } reg_idx_t;

    localparam int SPLIT_BITS = 23;
    localparam int LIMIT_BITS = 51;
    localparam int CFG_BITS   = 51;

    localparam logic [SPLIT_BITS-1:0] SPLIT_RESET = 23'd3840;
    localparam logic [LIMIT_BITS-1:0] HIGH_RESET  = 51'd262144;
    localparam logic [LIMIT_BITS-1:0] LOW_RESET   = 51'd189399;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DECIDE
    } state_t;

    // Control handed from the controller to the cell chains.
    typedef struct packed {
        logic clear;
        logic shift;
        logic load;
    } chain_ctrl_t;

endpackage

// ===== rtl/nspc_if.sv =====
// Valid/ready channel interfaces for the classifier.
// Depends on nspc_pkg for the configuration data width.
interface nspc_in_if #(parameter int COORD_BITS = 24);
    logic                         valid;
    logic                         ready;
    logic [1:0]                   func;
    logic signed [COORD_BITS-1:0] pos_x;
    logic signed [COORD_BITS-1:0] pos_y;
    logic signed [COORD_BITS-1:0] pos_z;
    logic                         is_local_max;
    modport source (output valid, func, pos_x, pos_y, pos_z, is_local_max, input ready);
    modport sink   (input valid, func, pos_x, pos_y, pos_z, is_local_max, output ready);
endinterface

interface nspc_out_if;
    logic valid;
    logic ready;
    logic to_tree;
    logic stored;
    modport source (output valid, to_tree, stored, input ready);
    modport sink   (input valid, to_tree, stored, output ready);
endinterface

interface nspc_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    index;
    logic [nspc_pkg::CFG_BITS-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/nearest_set_point_classifier.sv =====
// Top level of the nearest set point classifier.
// Depends on nspc_pkg, the interfaces in nspc_if and nspc_chain.
//
// Each store is a row of SET_DEPTH cells. A start or seed request goes from the idle
// state straight to the decide state. A classify request passes through a scan
// state that latches every cell's query differences, drain shifts that carry the
// running minimum down both rows side by side, and the decide state that decides and
// appends. A new request is accepted only in the idle state. The result is held in
// an output register until taken, and the next request is accepted while it waits;
// only the next decision waits for the previous result to be taken.
module nearest_set_point_classifier #(
    parameter int SET_DEPTH  = 256,
    parameter int COORD_BITS = 24
) (
    input  logic               clk,
    input  logic               rst_n,
    nspc_in_if.sink            in_req,
    nspc_out_if.source         out_res,
    nspc_cfg_if.sink           cfg
);
    localparam int DW = 2*COORD_BITS + 1;
    localparam int CW = $clog2(SET_DEPTH + 2);

    nspc_pkg::state_t state_reg;
    nspc_pkg::state_t state_next;

    logic [nspc_pkg::SPLIT_BITS-1:0] split_reg;
    logic [nspc_pkg::LIMIT_BITS-1:0] high_reg;
    logic [nspc_pkg::LIMIT_BITS-1:0] low_reg;

    logic [1:0]                   func_reg;
    logic signed [COORD_BITS-1:0] x_reg;
    logic signed [COORD_BITS-1:0] y_reg;
    logic signed [COORD_BITS-1:0] z_reg;
    logic                         lmax_reg;
    logic [CW-1:0]                cnt_reg;
    logic                         tt_reg;
    logic                         tt_next;
    logic                         st_reg;
    logic                         st_next;
    logic                         out_valid_reg;
    logic                         dec_go;

    nspc_pkg::chain_ctrl_t tctrl;
    nspc_pkg::chain_ctrl_t octrl;
    logic tree_app;
    logic other_app;
    logic tree_full;
    logic other_full;
    logic tv;
    logic ov;
    logic [DW-1:0] td;
    logic [DW-1:0] od;
    logic dt_le_dn;
    logic dt_le_lim;
    logic [nspc_pkg::LIMIT_BITS-1:0] lim;
    logic in_acc;

    assign in_acc    = in_req.valid && in_req.ready;
    assign cfg.ready = 1'b1;

    // A decision goes ahead once the output register is free or being emptied.
    assign dec_go = (state_reg == nspc_pkg::ST_DECIDE) && (!out_valid_reg || out_res.ready);

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            split_reg <= nspc_pkg::SPLIT_RESET;
            high_reg  <= nspc_pkg::HIGH_RESET;
            low_reg   <= nspc_pkg::LOW_RESET;
        end
        else if (cfg.valid)
        begin
            case (nspc_pkg::reg_idx_t'(cfg.index))
                nspc_pkg::REG_HEIGHT_SPLIT: split_reg <= cfg.data[nspc_pkg::SPLIT_BITS-1:0];
                nspc_pkg::REG_LIMIT_HIGH:   high_reg  <= cfg.data[nspc_pkg::LIMIT_BITS-1:0];
                nspc_pkg::REG_LIMIT_LOW:    low_reg   <= cfg.data[nspc_pkg::LIMIT_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Request capture.
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            func_reg <= in_req.func;
            x_reg    <= in_req.pos_x;
            y_reg    <= in_req.pos_y;
            z_reg    <= in_req.pos_z;
            lmax_reg <= in_req.is_local_max;
        end
    end

    // Decision, with empty sets as infinitely far.
    always_comb
    begin
        lim       = ($signed({1'b0, split_reg}) < z_reg) ? high_reg : low_reg;
        dt_le_dn  = !ov || (tv && td <= od);
        dt_le_lim = tv && (64'(td) <= 64'(lim));
        tt_next   = tt_reg;
        st_next   = st_reg;
        case (nspc_pkg::func_t'(func_reg))
            nspc_pkg::FUNC_START:
            begin
                tt_next = 1'b1;
                st_next = 1'b1;
            end
            nspc_pkg::FUNC_SEED:
            begin
                tt_next = 1'b0;
                st_next = !other_full;
            end
            nspc_pkg::FUNC_CLASSIFY:
            begin
                tt_next = lmax_reg ? dt_le_dn : (dt_le_lim && dt_le_dn);
                st_next = tt_next ? !tree_full : !other_full;
            end
            default: ;
        endcase
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            nspc_pkg::ST_IDLE:
                if (in_acc && in_req.func != nspc_pkg::FUNC_NONE)
                    state_next = (in_req.func == nspc_pkg::FUNC_CLASSIFY)
                               ? nspc_pkg::ST_SCAN : nspc_pkg::ST_DECIDE;
            nspc_pkg::ST_SCAN:   state_next = nspc_pkg::ST_DRAIN;
            nspc_pkg::ST_DRAIN:
                if (cnt_reg == CW'(SET_DEPTH))
                    state_next = nspc_pkg::ST_DECIDE;
            nspc_pkg::ST_DECIDE:
                if (dec_go)
                    state_next = nspc_pkg::ST_IDLE;
            default:             state_next = nspc_pkg::ST_IDLE;
        endcase
    end

    // Outputs of the controller.
    always_comb
    begin
        in_req.ready  = (state_reg == nspc_pkg::ST_IDLE);
        tctrl = '{clear: 1'b0, shift: 1'b0, load: 1'b0};
        tctrl.load  = (state_reg == nspc_pkg::ST_SCAN);
        tctrl.shift = (state_reg == nspc_pkg::ST_DRAIN);
        octrl = tctrl;
        tree_app  = 1'b0;
        other_app = 1'b0;
        if (dec_go)
        begin
            case (nspc_pkg::func_t'(func_reg))
                nspc_pkg::FUNC_START:
                begin
                    tctrl.clear = 1'b1;
                    octrl.clear = 1'b1;
                    tree_app    = 1'b1;
                end
                nspc_pkg::FUNC_SEED:     other_app = 1'b1;
                nspc_pkg::FUNC_CLASSIFY:
                begin
                    tree_app  = tt_next;
                    other_app = !tt_next;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= nspc_pkg::ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= (state_reg == nspc_pkg::ST_DRAIN) ? cnt_reg + CW'(1) : '0;
        end
    end

    // Output register: filled by a decision, emptied when the result is taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (dec_go)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_res.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (dec_go)
        begin
            tt_reg <= tt_next;
            st_reg <= st_next;
        end
    end

    assign out_res.valid   = out_valid_reg;
    assign out_res.to_tree = tt_reg;
    assign out_res.stored  = st_reg;

    nspc_chain #(.SET_DEPTH(SET_DEPTH), .COORD_BITS(COORD_BITS)) u_tree (
        .clk(clk), .rst_n(rst_n), .ctrl(tctrl), .append(tree_app),
        .q_x(x_reg), .q_y(y_reg), .full(tree_full), .min_valid(tv), .min_dist(td)
    );

    nspc_chain #(.SET_DEPTH(SET_DEPTH), .COORD_BITS(COORD_BITS)) u_other (
        .clk(clk), .rst_n(rst_n), .ctrl(octrl), .append(other_app),
        .q_x(x_reg), .q_y(y_reg), .full(other_full), .min_valid(ov), .min_dist(od)
    );
endmodule

// ===== rtl/nspc_cell.sv =====
// One cell of a point store chain: holds one point and its absolute differences to the
// query, and passes its running minimum to the next cell. Depends on nspc_pkg.
module nspc_cell #(
    parameter int COORD_BITS = 24
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  nspc_pkg::chain_ctrl_t        ctrl,
    input  logic                         write_en,
    input  logic signed [COORD_BITS-1:0] wr_x,
    input  logic signed [COORD_BITS-1:0] wr_y,
    input  logic signed [COORD_BITS-1:0] q_x,
    input  logic signed [COORD_BITS-1:0] q_y,
    input  logic                         min_in_valid,
    input  logic [2*COORD_BITS:0]        min_in,
    output logic                         min_out_valid,
    output logic [2*COORD_BITS:0]        min_out
);
    localparam int DW = 2*COORD_BITS + 1;

    logic                         used_reg;
    logic signed [COORD_BITS-1:0] x_reg;
    logic signed [COORD_BITS-1:0] y_reg;
    logic [COORD_BITS-1:0]        dx_reg;
    logic [COORD_BITS-1:0]        dy_reg;
    logic [COORD_BITS-1:0]        dx_next;
    logic [COORD_BITS-1:0]        dy_next;
    logic [DW-1:0]                dist_next;
    logic                         mv_reg;
    logic                         mv_next;
    logic [DW-1:0]                min_reg;
    logic [DW-1:0]                min_next;
    logic signed [COORD_BITS:0]   ddx;
    logic signed [COORD_BITS:0]   ddy;

    // Stored point.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= 1'b0;
        end
        else if (ctrl.clear)
        begin
            used_reg <= 1'b0;
        end
        else if (write_en)
        begin
            used_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (write_en)
        begin
            x_reg <= wr_x;
            y_reg <= wr_y;
        end
    end

    // Stage one: absolute differences.
    always_comb
    begin
        ddx = {x_reg[COORD_BITS-1], x_reg} - {q_x[COORD_BITS-1], q_x};
        ddy = {y_reg[COORD_BITS-1], y_reg} - {q_y[COORD_BITS-1], q_y};
        dx_next = ddx[COORD_BITS] ? COORD_BITS'(-ddx) : ddx[COORD_BITS-1:0];
        dy_next = ddy[COORD_BITS] ? COORD_BITS'(-ddy) : ddy[COORD_BITS-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            dx_reg <= dx_next;
            dy_reg <= dy_next;
        end
    end

    // Stage two: squared distance, folded into the running minimum.
    always_comb
    begin
        dist_next = DW'(dx_reg * dx_reg) + DW'(dy_reg * dy_reg);
        mv_next   = min_in_valid | used_reg;
        if (!used_reg)
        begin
            min_next = min_in;
        end
        else if (!min_in_valid || dist_next < min_in)
        begin
            min_next = dist_next;
        end
        else
        begin
            min_next = min_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mv_reg <= 1'b0;
        end
        else if (ctrl.shift)
        begin
            mv_reg <= mv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.shift)
        begin
            min_reg <= min_next;
        end
    end

    assign min_out_valid = mv_reg;
    assign min_out       = min_reg;
endmodule

// ===== rtl/nspc_chain.sv =====
// A row of cells holding one point set, with its fill count and write pointer.
// Depends on nspc_pkg and nspc_cell.
module nspc_chain #(
    parameter int SET_DEPTH  = 256,
    parameter int COORD_BITS = 24
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  nspc_pkg::chain_ctrl_t        ctrl,
    input  logic                         append,
    input  logic signed [COORD_BITS-1:0] q_x,
    input  logic signed [COORD_BITS-1:0] q_y,
    output logic                         full,
    output logic                         min_valid,
    output logic [2*COORD_BITS:0]        min_dist
);
    localparam int DW = 2*COORD_BITS + 1;
    localparam int CW = $clog2(SET_DEPTH + 1);

    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [SET_DEPTH:0]       mv;
    logic [DW-1:0]            md [SET_DEPTH+1];

    assign full = (count_reg == CW'(SET_DEPTH));

    // Fill count; a clear and an append in one cycle leave one entry, even from a full row.
    always_comb
    begin
        count_next = count_reg;
        if (ctrl.clear)
        begin
            count_next = '0;
        end
        if (append && (ctrl.clear || !full))
        begin
            count_next = (ctrl.clear ? CW'(0) : count_reg) + CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    assign mv[0] = 1'b0;
    assign md[0] = '0;

    // The minimum ripples one cell per shift cycle down the row.
    for (genvar i = 0; i < SET_DEPTH; i++)
    begin : g_cell
        logic                  wen;
        nspc_pkg::chain_ctrl_t cctrl;
        assign wen = append && (ctrl.clear ? (i == 0) : (count_reg == CW'(i)));
        assign cctrl.clear = ctrl.clear && !wen;
        assign cctrl.shift = ctrl.shift;
        assign cctrl.load  = ctrl.load;
        nspc_cell #(.COORD_BITS(COORD_BITS)) u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .ctrl         (cctrl),
            .write_en     (wen),
            .wr_x         (q_x),
            .wr_y         (q_y),
            .q_x          (q_x),
            .q_y          (q_y),
            .min_in_valid (mv[i]),
            .min_in       (md[i]),
            .min_out_valid(mv[i+1]),
            .min_out      (md[i+1])
        );
    end

    assign min_valid = mv[SET_DEPTH];
    assign min_dist  = md[SET_DEPTH];
endmodule

// ===== test/nspc_test_if.sv =====
// Clock and reset generator for the classifier testbench.
// No dependencies; the channel interfaces themselves come from rtl/nspc_if.sv.
module nspc_clock_gen (
    output logic clk,
    output logic rst_n
);
    timeunit 1ns;
    timeprecision 1ps;

    // Free-running 10 ns clock.
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Reset held low from the start, released at a falling edge.
    initial
    begin
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end
endmodule

// ===== test/nearest_set_point_classifier_test.sv =====
// Testbench for nearest_set_point_classifier.
// Depends on nspc_pkg, rtl/nspc_if.sv and nspc_clock_gen; predicts set membership
// per request and checks each result against the oldest expectation.
module nearest_set_point_classifier_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = 256;
    localparam int CB    = 24;
    localparam longint CYCLE_LIMIT = 3000000;

    typedef struct packed {
        nspc_pkg::func_t      func;
        logic signed [CB-1:0] x;
        logic signed [CB-1:0] y;
        logic signed [CB-1:0] z;
        logic                 lmax;
    } point_req_t;

    typedef struct packed {
        logic to_tree;
        logic stored;
    } membership_t;

    logic clk, rst_n;
    nspc_clock_gen clkgen (.clk(clk), .rst_n(rst_n));

    nspc_in_if #(.COORD_BITS(CB)) in_ch ();
    nspc_out_if out_ch ();
    nspc_cfg_if cfg_ch ();

    nearest_set_point_classifier #(.SET_DEPTH(DEPTH), .COORD_BITS(CB)) dut (
        .clk(clk), .rst_n(rst_n), .in_req(in_ch.sink), .out_res(out_ch.source),
        .cfg(cfg_ch.sink)
    );

    // Predictor state: the two stores and the registers.
    logic signed [CB-1:0] tree_x [DEPTH];
    logic signed [CB-1:0] tree_y [DEPTH];
    logic signed [CB-1:0] ground_x [DEPTH];
    logic signed [CB-1:0] ground_y [DEPTH];
    int unsigned tree_n = 0;
    int unsigned ground_n = 0;
    logic [nspc_pkg::SPLIT_BITS-1:0] split_z;
    logic [nspc_pkg::LIMIT_BITS-1:0] lim_high, lim_low;

    point_req_t  pending_reqs [$];
    membership_t expected_members [$];
    int  mismatches = 0;
    longint cycles = 0;
    bit  req_taken;     // the offered request was accepted at the last rising edge
    bit  hold_mode;     // no idling at all on either side
    bit  stall_req;     // asks the receiver for one long hold-off
    bit  stall_done;
    int  stall_cycles;  // long receiver hold-off counter

    // Smallest squared planar distance to a store; all ones means empty.
    function automatic logic [64:0] nearest_sq(input bit to_tree_set,
                                               input logic signed [CB-1:0] px,
                                               input logic signed [CB-1:0] py);
        logic [64:0] best;
        logic signed [CB:0] dx, dy;
        logic [64:0] d;
        int unsigned n;
        best = {65{1'b1}};
        n = to_tree_set ? tree_n : ground_n;
        for (int i = 0; i < n; i++)
        begin
            dx = to_tree_set ? (px - tree_x[i]) : (px - ground_x[i]);
            dy = to_tree_set ? (py - tree_y[i]) : (py - ground_y[i]);
            d = 65'(dx * dx) + 65'(dy * dy);
            if (d < best)
                best = d;
        end
        return best;
    endfunction

    // Works out the membership result of one request and updates the stores.
    function automatic membership_t classify_point(input point_req_t r);
        membership_t m;
        logic [64:0] dt, dn, lim;
        if (r.func == nspc_pkg::FUNC_START)
        begin
            tree_n = 0;
            ground_n = 0;
            m.to_tree = 1'b1;
        end
        else if (r.func == nspc_pkg::FUNC_SEED)
            m.to_tree = 1'b0;
        else
        begin
            dt = nearest_sq(1'b1, r.x, r.y);
            dn = nearest_sq(1'b0, r.x, r.y);
            lim = ($signed(r.z) > $signed({1'b0, split_z})) ? 65'(lim_high) : 65'(lim_low);
            if (r.lmax)
                m.to_tree = (dt <= dn);
            else
                m.to_tree = (dt <= lim) && (dt <= dn);
        end
        if (m.to_tree)
        begin
            m.stored = (tree_n < DEPTH);
            if (m.stored)
            begin
                tree_x[tree_n] = r.x;
                tree_y[tree_n] = r.y;
                tree_n++;
            end
        end
        else
        begin
            m.stored = (ground_n < DEPTH);
            if (m.stored)
            begin
                ground_x[ground_n] = r.x;
                ground_y[ground_n] = r.y;
                ground_n++;
            end
        end
        return m;
    endfunction

    // Request driver: offers queued points, idling at random.
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid        <= 1'b0;
            in_ch.func         <= nspc_pkg::FUNC_START;
            in_ch.pos_x        <= '0;
            in_ch.pos_y        <= '0;
            in_ch.pos_z        <= '0;
            in_ch.is_local_max <= 1'b0;
        end
        else if (in_ch.valid && !req_taken)
            in_ch.valid <= 1'b1;
        else if (pending_reqs.size() > 0 && (hold_mode || $urandom_range(99) >= 35))
        begin
            in_ch.valid        <= 1'b1;
            in_ch.func         <= pending_reqs[0].func;
            in_ch.pos_x        <= pending_reqs[0].x;
            in_ch.pos_y        <= pending_reqs[0].y;
            in_ch.pos_z        <= pending_reqs[0].z;
            in_ch.is_local_max <= pending_reqs[0].lmax;
        end
        else
            in_ch.valid <= 1'b0;
    end

    // Acceptance: predict at the rising edge where the request is taken.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        req_taken <= rst_n && in_ch.valid && in_ch.ready;
        if (rst_n && in_ch.valid && in_ch.ready)
        begin
            if (in_ch.func != nspc_pkg::FUNC_NONE)
                expected_members = {expected_members, classify_point(pending_reqs[0])};
            void'(pending_reqs.pop_front());
        end
    end

    // Result receiver with random stalls and one long hold-off.
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            stall_cycles <= 0;
            stall_done   <= 1'b0;
        end
        else if (stall_req && !stall_done)
        begin
            stall_cycles <= 3000;
            stall_done   <= 1'b1;
            out_ch.ready <= 1'b0;
        end
        else if (stall_cycles > 0)
        begin
            stall_cycles <= stall_cycles - 1;
            out_ch.ready <= 1'b0;
        end
        else
            out_ch.ready <= hold_mode || ($urandom_range(99) >= 35);
    end

    // Result monitor.
    always @(posedge clk)
    begin
        membership_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (expected_members.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result to_tree=%b stored=%b",
                             out_ch.to_tree, out_ch.stored);
            end
            else
            begin
                want = expected_members.pop_front();
                if (want.to_tree !== out_ch.to_tree || want.stored !== out_ch.stored)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected to_tree=%b stored=%b got %b %b",
                                 want.to_tree, want.stored, out_ch.to_tree, out_ch.stored);
                end
            end
        end
    end

    // Timeout watchdog.
    always @(posedge clk)
    begin
        if (cycles > CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic logic signed [CB-1:0] rand_coord(input int spread);
        int unsigned sel;
        sel = $urandom_range(19);
        if (sel == 0)
            return {1'b0, {(CB-1){1'b1}}};
        else if (sel == 1)
            return {1'b1, {(CB-1){1'b0}}};
        else if (sel < 4)
            return CB'($urandom);
        else
            return CB'($signed($urandom_range(2 * spread)) - spread);
    endfunction

    task automatic add_point(input nspc_pkg::func_t f, input logic signed [CB-1:0] x,
                             input logic signed [CB-1:0] y, input logic signed [CB-1:0] z,
                             input logic lm);
        point_req_t r;
        r.func = f;
        r.x = x;
        r.y = y;
        r.z = z;
        r.lmax = lm;
        pending_reqs = {pending_reqs, r};
    endtask

    // Waits until all queued requests are taken and every result has come back.
    task automatic drain_all();
        while (pending_reqs.size() > 0 || expected_members.size() > 0)
            @(posedge clk);
        repeat (DEPTH + 20) @(posedge clk);
    endtask

    task automatic write_reg(input nspc_pkg::reg_idx_t idx,
                             input logic [nspc_pkg::CFG_BITS-1:0] val);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        if (idx == nspc_pkg::REG_HEIGHT_SPLIT)
            split_z = val[nspc_pkg::SPLIT_BITS-1:0];
        else if (idx == nspc_pkg::REG_LIMIT_HIGH)
            lim_high = val[nspc_pkg::LIMIT_BITS-1:0];
        else if (idx == nspc_pkg::REG_LIMIT_LOW)
            lim_low = val[nspc_pkg::LIMIT_BITS-1:0];
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Tree segmentation pass: start, up to three seeds, then mostly classify points.
    task automatic add_segment(input int n_class, input int spread);
        add_point(nspc_pkg::FUNC_START, rand_coord(spread), rand_coord(spread),
                  rand_coord(spread), 1'($urandom));
        repeat ($urandom_range(3)) add_point(nspc_pkg::FUNC_SEED, rand_coord(spread),
                  rand_coord(spread), rand_coord(spread), 1'($urandom));
        repeat (n_class)
        begin
            if ($urandom_range(19) == 0)
                add_point(nspc_pkg::func_t'($urandom_range(3)), rand_coord(spread),
                          rand_coord(spread), rand_coord(spread), 1'($urandom));
            else
                add_point(nspc_pkg::FUNC_CLASSIFY, rand_coord(spread), rand_coord(spread),
                          rand_coord(4000), ($urandom_range(4) == 0));
        end
    endtask

    initial
    begin
        logic [nspc_pkg::CFG_BITS-1:0] lim_vals [4];
        split_z = nspc_pkg::SPLIT_RESET;
        lim_high = nspc_pkg::HIGH_RESET;
        lim_low = nspc_pkg::LOW_RESET;
        hold_mode = 1'b0;
        stall_req = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = nspc_pkg::REG_HEIGHT_SPLIT;
        cfg_ch.data = '0;
        lim_vals = '{51'd0, 51'd189399, 51'd5000000, {51{1'b1}}};
        @(posedge rst_n);

        // Directed part on reset register values: extremes, seeds, ties, unknown code.
        add_point(nspc_pkg::FUNC_CLASSIFY, 24'sd5, 24'sd5, 24'sd0, 1'b1);
        add_point(nspc_pkg::FUNC_CLASSIFY, 24'sd9, 24'sd9, 24'sd0, 1'b0);
        add_point(nspc_pkg::FUNC_START, 24'sd0, 24'sd0, 24'sd0, 1'b0);
        add_point(nspc_pkg::FUNC_CLASSIFY, 24'sd10, 24'sd0, 24'sd0, 1'b0);
        add_point(nspc_pkg::FUNC_CLASSIFY, {1'b0, {23{1'b1}}}, {1'b0, {23{1'b1}}}, 24'sd0, 1'b1);
        add_point(nspc_pkg::FUNC_CLASSIFY, {1'b1, {23{1'b0}}}, {1'b1, {23{1'b0}}}, 24'sd0, 1'b0);
        add_point(nspc_pkg::FUNC_SEED, 24'sd100, 24'sd0, 24'sd0, 1'b0);
        add_point(nspc_pkg::FUNC_CLASSIFY, 24'sd50, 24'sd0, 24'sd0, 1'b0);
        add_point(nspc_pkg::FUNC_CLASSIFY, 24'sd50, 24'sd0, 24'sd0, 1'b1);
        add_point(nspc_pkg::FUNC_CLASSIFY, 24'sd0, 24'sd300, 24'sd3841, 1'b0);
        add_point(nspc_pkg::FUNC_CLASSIFY, 24'sd0, 24'sd300, 24'sd3840, 1'b0);
        add_point(nspc_pkg::FUNC_CLASSIFY, 24'sd0, 24'sd300, {1'b1, {23{1'b0}}}, 1'b0);
        add_point(nspc_pkg::FUNC_CLASSIFY, 24'sd0, -24'sd300, {1'b0, {23{1'b1}}}, 1'b0);
        add_point(nspc_pkg::FUNC_NONE, -24'sd1, -24'sd1, -24'sd1, 1'b1);
        add_point(nspc_pkg::FUNC_START, -24'sd1, -24'sd1, -24'sd1, 1'b1);
        add_point(nspc_pkg::FUNC_CLASSIFY, 24'sd1, 24'sd1, 24'sd0, 1'b0);
        drain_all();

        // Fill both stores to overflow with points near the origin.
        add_point(nspc_pkg::FUNC_START, 24'sd0, 24'sd0, 24'sd0, 1'b0);
        for (int i = 0; i < DEPTH + 3; i++)
            add_point(nspc_pkg::FUNC_SEED, CB'(i), 24'sd7, 24'sd0, 1'b0);
        for (int i = 0; i < DEPTH + 3; i++)
            add_point(nspc_pkg::FUNC_CLASSIFY, 24'sd0, -CB'(i), 24'sd0, 1'b1);
        add_point(nspc_pkg::FUNC_CLASSIFY, 24'sd500, 24'sd7, 24'sd0, 1'b0);
        add_point(nspc_pkg::FUNC_CLASSIFY, 24'sd0, -24'sd500, 24'sd0, 1'b1);

        // No idling for a while, then a long receiver hold-off.
        hold_mode = 1'b1;
        drain_all();
        hold_mode = 1'b0;
        add_segment(12, 800);
        stall_req = 1'b1;
        drain_all();

        // Random phases over several register settings.
        for (int phase = 0; phase < 8; phase++)
        begin
            write_reg(nspc_pkg::REG_HEIGHT_SPLIT, (phase == 0) ? '0 :
                      (phase == 1) ? nspc_pkg::CFG_BITS'({nspc_pkg::SPLIT_BITS{1'b1}}) :
                      nspc_pkg::CFG_BITS'($urandom_range(8000)));
            write_reg(nspc_pkg::REG_LIMIT_HIGH, lim_vals[phase % 4]);
            write_reg(nspc_pkg::REG_LIMIT_LOW, lim_vals[(phase + 2) % 4]);
            if (phase == 6)
                write_reg(nspc_pkg::REG_UNUSED, nspc_pkg::CFG_BITS'($urandom));
            for (int s = 0; s < 5; s++)
                add_segment($urandom_range(10, 24), (s % 3 == 0) ? 30000 : 1500);
            drain_all();
        end

        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
